[design/sjsr_pkg.sv]
// Shared types, widths and codes of the joint setpoint ramp.
`default_nettype none
package sjsr_pkg;

	localparam int JOINT_W     = 3;
	localparam int POS_W       = 32;
	localparam int GAP_W       = 33;
	localparam int SPD_W       = 25;
	localparam int CNT_W       = 4;
	localparam int FUNC_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int PROD_W      = SPD_W + GAP_W;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	localparam logic [SPD_W-1:0] MAX_SPEED_RST     = 25'd5033;
	localparam logic [SPD_W-1:0] DEFAULT_SPEED_RST = 25'd168;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_TARGET = 2'd1,
		FUNC_START  = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_SPEED     = 2'd0,
		CFG_DEFAULT_SPEED = 2'd1,
		CFG_JOINTS        = 2'd2
	} cfg_reg_t;

	// request to the shared multiply/divide unit
	typedef struct packed {
		logic             start;
		logic [SPD_W-1:0] speed;
		logic [GAP_W-1:0] gap;
		logic [GAP_W-1:0] largest;
	} md_req_t;

	typedef struct packed {
		logic             done;
		logic [SPD_W-1:0] quot;
	} md_rsp_t;

	function automatic logic [GAP_W-1:0] mag33(input logic [GAP_W-1:0] v);
		return v[GAP_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage
`default_nettype wire

[design/synchronized_joint_setpoint_ramp_core.sv]
// Synchronized joint setpoint ramp: one item in work at a time, s_axis_tready low meanwhile.
// Start loads and unused codes are taken in idle. Target element: setpoint store read
// (S_TG_RD), then target and gap written (S_TG_UPD). Closing element: gap check, then per
// active joint a step rescale (shift-add multiply, restoring divide in the shared unit).
// Tick: per active joint read, gap, update; the update waits while a pending result is not taken.
// Reset (arst_n low) resets control state; unwritten target/setpoint/step entries read zero.
`default_nettype none
module synchronized_joint_setpoint_ramp_core
	import sjsr_pkg::*;
#(
	parameter int NUM_JOINTS = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [SPD_W-1:0]       cfg_data,
	// input stream
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // joint[2:0], position[34:3], zero
	input  wire logic [FUNC_W-1:0]      s_axis_tuser,  // func[1:0]
	input  wire logic                   s_axis_tlast,  // last_target
	// result stream
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // out_joint[2:0], setpoint[34:3], zero
	output logic                        m_axis_tlast   // last
);

	localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_TK_RD, S_TK_DIF, S_TK_UPD, S_TG_RD, S_TG_UPD,
		S_CL_CHK, S_CL_RD, S_CL_RUN, S_CL_WAIT
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       i_q;
	logic [CNT_W-1:0]       tc_q;
	logic [GAP_W-1:0]       lg_q;
	logic [SPD_W-1:0]       max_speed_q;
	logic [SPD_W-1:0]       default_speed_q;
	logic [CNT_W-1:0]       joints_in_use_q;
	logic [NUM_JOINTS-1:0]  tgt_vld_q;
	logic [NUM_JOINTS-1:0]  sp_vld_q;
	logic [NUM_JOINTS-1:0]  stp_vld_q;
	logic                   m_tvalid_q;

	logic [POS_W-1:0]       pos_q;
	logic                   last_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic [GAP_W-1:0]       d_q;
	logic [POS_W-1:0]       sp_s_q;
	logic [POS_W-1:0]       tg_s_q;
	logic [SPD_W-1:0]       stp_s_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   m_tlast_q;

	logic                   s_fire;
	logic [FUNC_W-1:0]      s_func;
	logic [JOINT_W-1:0]     s_joint;
	logic [POS_W-1:0]       s_pos;
	logic [CNT_W-1:0]       n_act;
	logic                   start_we;
	logic                   slot_free;
	logic                   upd_fire;
	logic                   i_last;
	logic [IDX_W-1:0]       rd_idx;
	logic [IDX_W-1:0]       wr_idx;

	logic [POS_W-1:0]       tg_rd;
	logic [POS_W-1:0]       sp_rd;
	logic [SPD_W-1:0]       stp_rd;
	logic [GAP_W-1:0]       gap_rd;
	logic [POS_W-1:0]       tg_e;
	logic [POS_W-1:0]       sp_e;
	logic [SPD_W-1:0]       stp_e;

	logic [GAP_W-1:0]       d_calc;
	logic [GAP_W-1:0]       d_mag;
	logic                   snap;
	logic [POS_W-1:0]       sp_new;
	logic [GAP_W-1:0]       g;
	logic [GAP_W-1:0]       g_mag;
	logic [GAP_W-1:0]       gap_mag_e;

	logic                   tgt_we;
	logic                   sp_we;
	logic                   stp_we;
	logic                   gap_we;
	logic [POS_W-1:0]       tgt_wdata;
	logic [POS_W-1:0]       sp_wdata;
	logic [SPD_W-1:0]       stp_wdata;

	md_req_t                md_req;
	md_rsp_t                md_rsp;

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign s_func        = s_axis_tuser;
	assign s_joint       = s_axis_tdata[JOINT_W-1:0];
	assign s_pos         = s_axis_tdata[JOINT_W +: POS_W];

	assign n_act = (32'(joints_in_use_q) > NUM_JOINTS) ? CNT_W'(NUM_JOINTS) : joints_in_use_q;

	assign start_we  = s_fire && (s_func == FUNC_START) && ({1'b0, s_joint} < n_act);
	assign slot_free = !m_tvalid_q || m_axis_tready;
	assign upd_fire  = (state_q == S_TK_UPD) && slot_free;
	assign i_last    = ((i_q + 4'd1) == n_act);

	assign rd_idx = (state_q == S_TG_RD) ? IDX_W'(tc_q) : IDX_W'(i_q);
	assign wr_idx = start_we ? IDX_W'(s_joint) :
		(state_q == S_TG_UPD) ? IDX_W'(tc_q) : IDX_W'(i_q);

	// entries never written read as zero
	assign tg_e  = tgt_vld_q[rd_idx_q] ? tg_rd : '0;
	assign sp_e  = sp_vld_q[rd_idx_q] ? sp_rd : '0;
	assign stp_e = stp_vld_q[rd_idx_q] ? stp_rd : '0;

	// tick: setpoint minus target, then snap or one step toward the target
	assign d_calc = {sp_e[POS_W-1], sp_e} - {tg_e[POS_W-1], tg_e};
	assign d_mag  = mag33(d_q);
	assign snap   = (d_mag <= {{(GAP_W-SPD_W){1'b0}}, stp_s_q});
	assign sp_new = snap ? tg_s_q :
		d_q[GAP_W-1] ? (sp_s_q + {{(POS_W-SPD_W){1'b0}}, stp_s_q}) :
		(sp_s_q - {{(POS_W-SPD_W){1'b0}}, stp_s_q});

	// target element: gap against the current setpoint
	assign g     = {pos_q[POS_W-1], pos_q} - {sp_e[POS_W-1], sp_e};
	assign g_mag = mag33(g);

	// joints that got no target in this command have a zero gap
	assign gap_mag_e = (i_q < tc_q) ? mag33(gap_rd) : '0;

	assign md_req.start   = (state_q == S_CL_RUN);
	assign md_req.speed   = max_speed_q;
	assign md_req.gap     = gap_mag_e;
	assign md_req.largest = lg_q;

	assign tgt_we    = start_we || (state_q == S_TG_UPD);
	assign sp_we     = start_we || upd_fire;
	assign stp_we    = start_we || ((state_q == S_CL_WAIT) && md_rsp.done);
	assign gap_we    = (state_q == S_TG_UPD);
	assign tgt_wdata = start_we ? s_pos : pos_q;
	assign sp_wdata  = start_we ? s_pos : sp_new;
	assign stp_wdata = start_we ? default_speed_q : md_rsp.quot;

	sjsr_ram #(.WIDTH(POS_W), .DEPTH(NUM_JOINTS)) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (wr_idx),
		.wdata (tgt_wdata),
		.raddr (rd_idx),
		.rdata (tg_rd)
	);

	sjsr_ram #(.WIDTH(POS_W), .DEPTH(NUM_JOINTS)) u_sp_ram (
		.clk   (clk),
		.we    (sp_we),
		.waddr (wr_idx),
		.wdata (sp_wdata),
		.raddr (rd_idx),
		.rdata (sp_rd)
	);

	sjsr_ram #(.WIDTH(SPD_W), .DEPTH(NUM_JOINTS)) u_stp_ram (
		.clk   (clk),
		.we    (stp_we),
		.waddr (wr_idx),
		.wdata (stp_wdata),
		.raddr (rd_idx),
		.rdata (stp_rd)
	);

	sjsr_ram #(.WIDTH(GAP_W), .DEPTH(NUM_JOINTS)) u_gap_ram (
		.clk   (clk),
		.we    (gap_we),
		.waddr (wr_idx),
		.wdata (g),
		.raddr (rd_idx),
		.rdata (gap_rd)
	);

	sjsr_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			i_q             <= '0;
			tc_q            <= '0;
			lg_q            <= '0;
			max_speed_q     <= MAX_SPEED_RST;
			default_speed_q <= DEFAULT_SPEED_RST;
			joints_in_use_q <= '0;
			tgt_vld_q       <= '0;
			sp_vld_q        <= '0;
			stp_vld_q       <= '0;
			m_tvalid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MAX_SPEED:     max_speed_q     <= cfg_data;
					CFG_DEFAULT_SPEED: default_speed_q <= cfg_data;
					CFG_JOINTS:        joints_in_use_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end

			if (upd_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (start_we) begin
				tgt_vld_q[wr_idx] <= 1'b1;
				sp_vld_q[wr_idx]  <= 1'b1;
				stp_vld_q[wr_idx] <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						unique case (s_func)
							FUNC_TICK: begin
								if (n_act != '0) begin
									i_q     <= '0;
									state_q <= S_TK_RD;
								end
							end
							FUNC_TARGET: begin
								if (tc_q < n_act) begin
									state_q <= S_TG_RD;
								end else if (s_axis_tlast) begin
									state_q <= S_CL_CHK;
								end
							end
							default: ;
						endcase
					end
				end
				S_TK_RD:  state_q <= S_TK_DIF;
				S_TK_DIF: state_q <= S_TK_UPD;
				S_TK_UPD: begin
					if (slot_free) begin
						sp_vld_q[wr_idx] <= 1'b1;
						if (i_last) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + 4'd1;
							state_q <= S_TK_RD;
						end
					end
				end
				S_TG_RD: state_q <= S_TG_UPD;
				S_TG_UPD: begin
					tgt_vld_q[wr_idx] <= 1'b1;
					if (g_mag > lg_q) begin
						lg_q <= g_mag;
					end
					tc_q    <= tc_q + 4'd1;
					state_q <= last_q ? S_CL_CHK : S_IDLE;
				end
				S_CL_CHK: begin
					// all gaps zero or no active joints: steps keep their values
					if ((lg_q == '0) || (n_act == '0)) begin
						tc_q    <= '0;
						lg_q    <= '0;
						state_q <= S_IDLE;
					end else begin
						i_q     <= '0;
						state_q <= S_CL_RD;
					end
				end
				S_CL_RD:  state_q <= S_CL_RUN;
				S_CL_RUN: state_q <= S_CL_WAIT;
				S_CL_WAIT: begin
					if (md_rsp.done) begin
						stp_vld_q[wr_idx] <= 1'b1;
						if (i_last) begin
							tc_q    <= '0;
							lg_q    <= '0;
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + 4'd1;
							state_q <= S_CL_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			pos_q  <= s_pos;
			last_q <= s_axis_tlast;
		end
		rd_idx_q <= rd_idx;
		if (state_q == S_TK_DIF) begin
			d_q     <= d_calc;
			sp_s_q  <= sp_e;
			tg_s_q  <= tg_e;
			stp_s_q <= stp_e;
		end
		if (upd_fire) begin
			m_tdata_q <= {{(OUT_TDATA_W-JOINT_W-POS_W){1'b0}}, sp_new, i_q[JOINT_W-1:0]};
			m_tlast_q <= i_last;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tlast  = m_tlast_q;

endmodule
`default_nettype wire

[design/sjsr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sjsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[design/sjsr_muldiv.sv]
// Shared shift-add multiplier and restoring divider: floor(speed * gap / largest).
`default_nettype none
module sjsr_muldiv
	import sjsr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire md_req_t req,
	output md_rsp_t      rsp
);

	typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

	localparam logic [4:0] STEP_LAST = 5'(SPD_W - 1);

	md_state_t         state_q;
	logic [4:0]        cnt_q;
	logic              done_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] mcand_q;
	logic [SPD_W-1:0]  mplier_q;
	logic [GAP_W-1:0]  lg_q;

	logic [PROD_W-1:0] op_a;
	logic [PROD_W-1:0] op_b;
	logic              cin;
	logic [PROD_W-1:0] sum;
	logic              ge;

	// one adder serves both phases; in the divide phase it subtracts the divisor
	always_comb begin
		if (state_q == MD_DIV) begin
			op_a = {{(PROD_W-GAP_W-1){1'b0}}, acc_q[PROD_W-1:SPD_W-1]};
			op_b = ~{{(PROD_W-GAP_W){1'b0}}, lg_q};
			cin  = 1'b1;
		end else begin
			op_a = acc_q;
			op_b = mplier_q[0] ? mcand_q : '0;
			cin  = 1'b0;
		end
		sum = op_a + op_b + {{(PROD_W-1){1'b0}}, cin};
		ge  = ~sum[PROD_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				MD_IDLE: begin
					if (req.start) begin
						cnt_q   <= '0;
						state_q <= MD_MUL;
					end
				end
				MD_MUL: begin
					if (cnt_q == STEP_LAST) begin
						cnt_q   <= '0;
						state_q <= MD_DIV;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				MD_DIV: begin
					if (cnt_q == STEP_LAST) begin
						done_q  <= 1'b1;
						state_q <= MD_IDLE;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	// quotient < 2^25, so the high part starts below the divisor and the
	// quotient bits shift into the low end of the accumulator
	always_ff @(posedge clk) begin
		unique case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					acc_q    <= '0;
					mcand_q  <= {{(PROD_W-GAP_W){1'b0}}, req.gap};
					mplier_q <= req.speed;
					lg_q     <= req.largest;
				end
			end
			MD_MUL: begin
				acc_q    <= sum;
				mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[SPD_W-1:1]};
			end
			MD_DIV: begin
				acc_q <= {(ge ? sum[GAP_W-1:0] : acc_q[PROD_W-2:SPD_W-1]),
					acc_q[SPD_W-2:0], ge};
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.quot = acc_q[SPD_W-1:0];

endmodule
`default_nettype wire

[design/sjsr_checker.sv]
// Port-level checks of the joint setpoint ramp, bound to the top level.
`default_nettype none
module sjsr_checker
	import sjsr_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic [FUNC_W-1:0]      s_axis_tuser,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic                   m_axis_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// a start load completes within its transfer cycle
	a_start_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_START) |=> s_axis_tready)
		else $error("start load kept the block busy");

	// results only come out of work in progress, never straight from idle
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without work in progress");

endmodule

bind synchronized_joint_setpoint_ramp_core sjsr_checker u_sjsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
